>>> hdl/srl_pkg.sv
// Package for the sorted render list: sizes, operation and status codes,
// and the command/status structs between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package srl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_SENT     = 3'd2;
    localparam logic [ST_W-1:0] ST_NONE     = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic            latch;      // capture the accepted input item
        logic            clear;      // empty the list
        logic            cmp;        // register the key comparisons
        logic            ins_write;  // shift the chain and write the new entry
        logic            rot;        // rotate the chain by one cell
        logic            step_clr;   // start a drain walk
        logic            pend_load;  // hold cell 0 as the pending entry
        logic            push;       // load the output register
        logic            push_pend;  // output carries the pending entry
        logic            push_last;
        logic [ST_W-1:0] push_status;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            out_free;
        logic            cand;       // cell 0 is a live entry with nonzero payload
        logic            have_pend;
        logic            step_done;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/srl_in_if.sv
// Input channel of the sorted render list: valid/ready handshake with the
// operation, key and payload. Depends on srl_pkg for the field widths.
`default_nettype none

interface srl_in_if;
    logic                        valid;
    logic                        ready;
    logic [srl_pkg::OP_W-1:0]    op;
    logic signed [srl_pkg::KEY_W-1:0] key;
    logic [srl_pkg::PAY_W-1:0]   payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/srl_out_if.sv
// Result channel of the sorted render list: valid/ready handshake with the
// status, key, payload and last flag. Depends on srl_pkg for the field widths.
`default_nettype none

interface srl_out_if;
    logic                             valid;
    logic                             ready;
    logic [srl_pkg::ST_W-1:0]         status;
    logic signed [srl_pkg::KEY_W-1:0] out_key;
    logic [srl_pkg::PAY_W-1:0]        out_payload;
    logic                             last;

    modport source (output valid, output status, output out_key, output out_payload,
                    output last, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input last, output ready);
endinterface

`default_nettype wire

>>> hdl/sorted_render_list.sv
// Sorted render list, top level: joins the controller and the datapath to
// the input and result channels. Depends on srl_pkg, srl_in_if, srl_out_if,
// srl_ctrl and srl_dp.
//
// Usage: items arrive on i_in (op, key, payload) and results leave on o_out
// (status, out_key, out_payload, last); each side transfers when valid and
// ready are both high. The list holds up to CAPACITY entries in ascending
// signed key order, a new entry ahead of equal keys, in a chain of cells.
// Order of work: a clear or a dropped insert is latched, then answered; an
// insert is latched, compared, then shifted and written. A drain rotates
// the whole chain once, one cell per cycle unless a stalled output holds it
// at an entry to send, then sees the walk done and loads the final result;
// results come out as the walk finds them, the final one held until the end
// to carry last. One item is worked at a time; the next one is taken as
// soon as the last result of the previous item sits in the output register.
// Reset empties the list and the output register; no clearing pass runs.
// When the receiver stalls, the output register holds its result and the
// walk or the pending operation waits until the register frees up.
`default_nettype none

module sorted_render_list (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srl_in_if.sink     i_in,
    srl_out_if.source  o_out
);

    srl_pkg::t_cmd cmd;
    srl_pkg::t_sts sts;

    srl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    srl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_in.op),
        .i_key         (i_in.key),
        .i_payload     (i_in.payload),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status      (o_out.status),
        .o_out_key     (o_out.out_key),
        .o_out_payload (o_out.out_payload),
        .o_last        (o_out.last)
    );

endmodule

`default_nettype wire

>>> hdl/srl_ctrl.sv
// Controller of the sorted render list: sequences clear, insert and drain
// through the datapath by commands. Depends on srl_pkg.
`default_nettype none

module srl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output srl_pkg::t_cmd      o_cmd,
    input  wire srl_pkg::t_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    srl_pkg::OP_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.clear       = 1'b1;
                            o_cmd.push        = 1'b1;
                            o_cmd.push_last   = 1'b1;
                            o_cmd.push_status = srl_pkg::ST_CLEARED;
                            n_state           = S_IDLE;
                        end
                    end
                    srl_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            if (i_sts.out_free) begin
                                o_cmd.push        = 1'b1;
                                o_cmd.push_last   = 1'b1;
                                o_cmd.push_status = srl_pkg::ST_FULL;
                                n_state           = S_IDLE;
                            end
                        end else begin
                            o_cmd.cmp = 1'b1;
                            n_state   = S_INSERT;
                        end
                    end
                    srl_pkg::OP_DRAIN: begin
                        o_cmd.step_clr = 1'b1;
                        n_state        = S_DRAIN;
                    end
                    default: begin
                        // An unused code is dropped without a result.
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INSERT: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_write   = 1'b1;
                    o_cmd.push        = 1'b1;
                    o_cmd.push_last   = 1'b1;
                    o_cmd.push_status = srl_pkg::ST_INSERTED;
                    n_state           = S_IDLE;
                end
            end
            S_DRAIN: begin
                // One entry held back so that the final one can carry last.
                if (i_sts.step_done) begin
                    n_state = S_FINISH;
                end else if (i_sts.cand) begin
                    if (!i_sts.have_pend) begin
                        o_cmd.pend_load = 1'b1;
                        o_cmd.rot       = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.push_pend   = 1'b1;
                        o_cmd.push_status = srl_pkg::ST_SENT;
                        o_cmd.pend_load   = 1'b1;
                        o_cmd.rot         = 1'b1;
                    end
                end else begin
                    o_cmd.rot = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    if (i_sts.have_pend) begin
                        o_cmd.push_pend   = 1'b1;
                        o_cmd.push_status = srl_pkg::ST_SENT;
                    end else begin
                        o_cmd.push_status = srl_pkg::ST_NONE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/srl_dp.sv
// Datapath of the sorted render list: the sorted cell chain, the drain walk
// counter, the pending entry and the output register. Depends on srl_pkg.
`default_nettype none

module srl_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire srl_pkg::t_cmd               i_cmd,
    output srl_pkg::t_sts                    o_sts,
    input  wire logic [srl_pkg::OP_W-1:0]    i_op,
    input  wire logic [srl_pkg::KEY_W-1:0]   i_key,
    input  wire logic [srl_pkg::PAY_W-1:0]   i_payload,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [srl_pkg::ST_W-1:0]         o_status,
    output logic [srl_pkg::KEY_W-1:0]        o_out_key,
    output logic [srl_pkg::PAY_W-1:0]        o_out_payload,
    output logic                             o_last
);

    localparam int CAP = srl_pkg::CAPACITY;

    logic [srl_pkg::OP_W-1:0]  r_op;
    logic [srl_pkg::KEY_W-1:0] r_key_in;
    logic [srl_pkg::PAY_W-1:0] r_pay_in;

    logic [srl_pkg::KEY_W-1:0] r_cell_key [CAP];
    logic [srl_pkg::PAY_W-1:0] r_cell_pay [CAP];
    logic [srl_pkg::KEY_W-1:0] n_cell_key [CAP];
    logic [srl_pkg::PAY_W-1:0] n_cell_pay [CAP];

    logic [CAP-1:0]            gt_c;
    logic [CAP-1:0]            r_gt;
    logic [srl_pkg::CNT_W-1:0] r_count;
    logic [srl_pkg::CNT_W-1:0] r_step;
    logic                      r_have_pend;
    logic [srl_pkg::KEY_W-1:0] r_pend_key;
    logic [srl_pkg::PAY_W-1:0] r_pend_pay;
    logic                      out_free;

    assign out_free = !o_out_valid || i_out_ready;

    // Each cell compares the new key against its own entry; the list is
    // sorted, so the set of cells with a smaller key is a prefix.
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        assign gt_c[g] = (srl_pkg::CNT_W'(g) < r_count)
                         && ($signed(r_key_in) > $signed(r_cell_key[g]));
        if (g == 0) begin : g_head
            always_comb begin
                if (i_cmd.rot) begin
                    n_cell_key[g] = r_cell_key[(g + 1) % CAP];
                    n_cell_pay[g] = r_cell_pay[(g + 1) % CAP];
                end else if (r_gt[g]) begin
                    n_cell_key[g] = r_cell_key[g];
                    n_cell_pay[g] = r_cell_pay[g];
                end else begin
                    n_cell_key[g] = r_key_in;
                    n_cell_pay[g] = r_pay_in;
                end
            end
        end else begin : g_body
            always_comb begin
                if (i_cmd.rot) begin
                    n_cell_key[g] = r_cell_key[(g + 1) % CAP];
                    n_cell_pay[g] = r_cell_pay[(g + 1) % CAP];
                end else if (r_gt[g]) begin
                    n_cell_key[g] = r_cell_key[g];
                    n_cell_pay[g] = r_cell_pay[g];
                end else if (r_gt[g-1]) begin
                    n_cell_key[g] = r_key_in;
                    n_cell_pay[g] = r_pay_in;
                end else begin
                    n_cell_key[g] = r_cell_key[g-1];
                    n_cell_pay[g] = r_cell_pay[g-1];
                end
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_op;
            r_key_in <= i_key;
            r_pay_in <= i_payload;
        end
        if (i_cmd.cmp) begin
            r_gt <= gt_c;
        end
        if (i_cmd.ins_write || i_cmd.rot) begin
            r_cell_key <= n_cell_key;
            r_cell_pay <= n_cell_pay;
        end
        if (i_cmd.pend_load) begin
            r_pend_key <= r_cell_key[0];
            r_pend_pay <= r_cell_pay[0];
        end
        if (i_cmd.push) begin
            o_status      <= i_cmd.push_status;
            o_out_key     <= i_cmd.push_pend ? r_pend_key : '0;
            o_out_payload <= i_cmd.push_pend ? r_pend_pay : '0;
            o_last        <= i_cmd.push_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_step      <= '0;
            r_have_pend <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.ins_write) begin
                r_count <= r_count + srl_pkg::CNT_W'(1);
            end
            if (i_cmd.step_clr) begin
                r_step      <= '0;
                r_have_pend <= 1'b0;
            end else begin
                if (i_cmd.rot) begin
                    r_step <= r_step + srl_pkg::CNT_W'(1);
                end
                if (i_cmd.pend_load) begin
                    r_have_pend <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.full      = (r_count == srl_pkg::CNT_W'(CAP));
        o_sts.out_free  = out_free;
        o_sts.cand      = (r_step < r_count) && (r_cell_pay[0] != '0);
        o_sts.have_pend = r_have_pend;
        o_sts.step_done = (r_step == srl_pkg::CNT_W'(CAP));
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srl_pkg::CNT_W'(CAP))
        else $error("entry count above capacity");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= srl_pkg::CNT_W'(CAP))
        else $error("drain walk ran past the chain");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("result overwrites one not yet transferred");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> !o_sts.full)
        else $error("insert into a full list");

    a_rot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rot |=> r_step == $past(r_step) + srl_pkg::CNT_W'(1))
        else $error("rotation without a walk step");

endmodule

`default_nettype wire
